>>> rtl/pixel_lightness_adjust_macros.svh
// Assertion macros shared by the pixel lightness adjust RTL.
`ifndef PIXEL_LIGHTNESS_ADJUST_MACROS_SVH
`define PIXEL_LIGHTNESS_ADJUST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PLA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define PLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/plad_pkg.sv
// Shared types and constants for the pixel lightness adjust block.
`timescale 1ns / 1ps
package plad_pkg;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DARKEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 8'd1;

    // Divider geometry: 17-bit dividend, 8-bit divisor, 9 quotient bits.
    localparam int DIV_QW = 9;
    localparam int DIV_NW = 17;
    localparam int DIV_DW = 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] light_pct;
    } t_pix_out;

    // Per-pixel data riding alongside the divider.
    typedef struct packed {
        logic [7:0] alpha;
        logic [6:0] light;
        logic [6:0] v;
    } t_side;

endpackage

>>> rtl/plad_rgb_to_hsl.sv
// Front end: max/min, lightness, adjusted lightness and divider operands.
`timescale 1ns / 1ps
module plad_rgb_to_hsl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  plad_pkg::t_pix_in              i_pix,
    input  logic                           i_darken,
    input  logic [6:0]                     i_step,
    output logic                           o_valid,
    output plad_pkg::t_side                o_side,
    output logic [plad_pkg::DIV_NW-1:0]    o_num_s,
    output logic [plad_pkg::DIV_DW-1:0]    o_den_s,
    output logic [plad_pkg::DIV_NW-1:0]    o_num_h,
    output logic [plad_pkg::DIV_DW-1:0]    o_den_h
);

    logic              r_v1;
    plad_pkg::t_pix_in r_pix1;
    logic [7:0]        r_mx1;
    logic [7:0]        r_mn1;
    logic [7:0]        mx;
    logic [7:0]        mn;

    // stage 1: extremes
    always_comb begin
        mx = i_pix.red;
        mn = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx) mx = i_pix.blue;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn) mn = i_pix.blue;
    end

    // stage 2 combinational
    logic [8:0]         sum;
    logic [7:0]         d;
    logic [12:0]        x10;
    logic [25:0]        lprod;
    logic [6:0]         light;
    logic [7:0]         vsum;
    logic [6:0]         v;
    logic [8:0]         den_hi;
    logic [7:0]         den_s;
    logic [14:0]        num_s;
    logic signed [18:0] sd;
    logic signed [18:0] nh;

    always_comb begin
        sum    = {1'b0, r_mx1} + {1'b0, r_mn1};
        d      = r_mx1 - r_mn1;
        x10    = {1'b0, sum, 3'b000} + {3'b000, sum, 1'b0};
        lprod  = 26'(x10) * 26'd5141;       // floor(10*sum/51)
        light  = lprod[24:18];
        vsum   = {1'b0, light} + {1'b0, i_step};
        if (i_darken) begin
            v = (i_step >= light) ? 7'd0 : 7'(light - i_step);
        end else begin
            v = (vsum > 8'd100) ? 7'd100 : vsum[6:0];
        end
        den_hi = 9'd510 - sum;
        if (d == 8'd0) den_s = 8'd1;
        else if (sum < 9'd255) den_s = sum[7:0];
        else den_s = den_hi[7:0];
        num_s  = 15'(d) * 15'd100;
        sd     = $signed({11'b0, d});
        // blue wins ties, then green
        if (r_pix1.blue == r_mx1) begin
            nh = 19'sd240 * sd + 19'sd60 * ($signed({11'b0, r_pix1.red})
                 - $signed({11'b0, r_pix1.green}));
        end else if (r_pix1.green == r_mx1) begin
            nh = 19'sd120 * sd + 19'sd60 * ($signed({11'b0, r_pix1.blue})
                 - $signed({11'b0, r_pix1.red}));
        end else begin
            nh = 19'sd60 * ($signed({11'b0, r_pix1.green})
                 - $signed({11'b0, r_pix1.blue}));
            if (nh < 0) nh = nh + 19'sd360 * sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix1       <= i_pix;
            r_mx1        <= mx;
            r_mn1        <= mn;
            o_side.alpha <= r_pix1.alpha;
            o_side.light <= light;
            o_side.v     <= v;
            o_num_s      <= (d == 8'd0) ? '0 : 17'(num_s);
            o_den_s      <= den_s;
            o_num_h      <= (d == 8'd0) ? '0 : nh[16:0];
            o_den_h      <= (d == 8'd0) ? 8'd1 : d;
        end
    end

endmodule

>>> rtl/plad_div.sv
// Two-lane restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module plad_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  plad_pkg::t_side             i_side,
    input  logic [plad_pkg::DIV_NW-1:0] i_num_s,
    input  logic [plad_pkg::DIV_DW-1:0] i_den_s,
    input  logic [plad_pkg::DIV_NW-1:0] i_num_h,
    input  logic [plad_pkg::DIV_DW-1:0] i_den_h,
    output logic                        o_valid,
    output plad_pkg::t_side             o_side,
    output logic [6:0]                  o_sat,
    output logic [8:0]                  o_hue
);

    typedef struct packed {
        logic [plad_pkg::DIV_NW-1:0] rem;
        logic [plad_pkg::DIV_DW-1:0] den;
        logic [plad_pkg::DIV_QW-1:0] quo;
    } t_lane;

    function automatic t_lane div_step(input t_lane x, input logic [3:0] sh);
        logic [24:0] dsh;
        t_lane       y;
        y   = x;
        dsh = {17'b0, x.den} << sh;
        if ({8'b0, x.rem} >= dsh) begin
            y.rem     = x.rem - dsh[16:0];
            y.quo[sh] = 1'b1;
        end
        return y;
    endfunction

    t_lane                       r_s [plad_pkg::DIV_QW];
    t_lane                       r_h [plad_pkg::DIV_QW];
    plad_pkg::t_side             r_side [plad_pkg::DIV_QW];
    logic [plad_pkg::DIV_QW-1:0] r_vld;
    t_lane                       in_s;
    t_lane                       in_h;

    assign in_s = '{rem: i_num_s, den: i_den_s, quo: '0};
    assign in_h = '{rem: i_num_h, den: i_den_h, quo: '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[plad_pkg::DIV_QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]    <= div_step(in_s, 4'(plad_pkg::DIV_QW - 1));
            r_h[0]    <= div_step(in_h, 4'(plad_pkg::DIV_QW - 1));
            r_side[0] <= i_side;
            for (int k = 1; k < plad_pkg::DIV_QW; k++) begin
                r_s[k]    <= div_step(r_s[k-1], 4'(plad_pkg::DIV_QW - 1 - k));
                r_h[k]    <= div_step(r_h[k-1], 4'(plad_pkg::DIV_QW - 1 - k));
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[plad_pkg::DIV_QW-1];
    assign o_side  = r_side[plad_pkg::DIV_QW-1];
    assign o_sat   = r_s[plad_pkg::DIV_QW-1].quo[6:0];
    assign o_hue   = r_h[plad_pkg::DIV_QW-1].quo;

endmodule

>>> rtl/plad_hsl_to_rgb.sv
// Back end: Q16 HSL to RGB sector rule and percent-to-byte scaling.
`timescale 1ns / 1ps
module plad_hsl_to_rgb (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  plad_pkg::t_side    i_side,
    input  logic [8:0]         i_hue,
    input  logic [6:0]         i_sat,
    output logic               o_valid,
    output plad_pkg::t_pix_out o_pix
);

    localparam int NST = 6;

    typedef struct packed {
        logic [7:0] alpha;
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] light;
        logic [6:0] v;
        logic       gray;
    } t_meta;

    typedef enum logic [1:0] {SEC_RISE, SEC_HIGH, SEC_FALL, SEC_LOW} t_sector;

    // floor(p*65536/100) = 655p + floor(9p/25)
    function automatic logic [16:0] q16_pct(input logic [6:0] p);
        logic [9:0]  x9;
        logic [15:0] m;
        x9 = 10'(p) * 10'd9;
        m  = 16'(x9) * 16'd41;
        return 17'(p) * 17'd655 + 17'(m[15:10]);
    endfunction

    logic [NST-1:0] r_vld;
    t_meta          r_meta [NST];

    // B1
    logic [16:0] r1_lq, r1_sq, r1_hq;
    logic [20:0] hx;
    logic [16:0] hq;
    // B2
    logic [17:0] r2_t1;
    logic [16:0] r2_lq;
    logic [16:0] r2_ph [3];
    logic [32:0] pa;
    logic [33:0] pb;
    logic [17:0] t1;
    logic [16:0] ph [3];
    // B3
    logic [17:0] r3_t1, r3_t2;
    logic [16:0] r3_diff;
    logic [16:0] r3_ph [3];
    logic [17:0] lq2, t2, dfull;
    // B4
    t_sector     r4_sec [3];
    logic [16:0] r4_add [3];
    logic [17:0] r4_t1, r4_t2;
    t_sector     sec [3];
    logic [15:0] mul [3];
    logic [32:0] prod [3];
    logic [19:0] t6 [3];
    logic [16:0] kk [3];
    // B5
    logic [6:0]  r5_p [3];
    logic [18:0] c [3];
    logic [25:0] cp [3];
    logic [6:0]  p [3];
    // B6
    logic [10:0] r6_y [3];
    logic [6:0]  pick [3];
    logic [12:0] y51 [3];
    // B7
    logic [21:0] bp [3];

    always_comb begin
        hx = 21'(i_hue) * 21'd2914;     // floor(2h/45) via 2*1457
        hq = 17'(i_hue) * 17'd182 + 17'(hx[20:16]);
    end

    always_comb begin
        pa = 33'(r1_lq[14:0]) * (33'd65536 + 33'(r1_sq));
        pb = 34'(r1_lq) * 34'(r1_sq);
        if (r1_lq < 17'd32768) t1 = 18'(pa[32:16]);
        else t1 = 18'(r1_lq) + 18'(r1_sq) - pb[33:16];
        ph[0] = ((r1_hq + 17'd21843) > 17'd65536) ? r1_hq + 17'd21843 - 17'd65536
                                                  : r1_hq + 17'd21843;
        ph[1] = r1_hq;
        ph[2] = (r1_hq >= 17'd21843) ? r1_hq - 17'd21843
                                     : r1_hq + 17'd65536 - 17'd21843;
    end

    always_comb begin
        lq2   = {r2_lq, 1'b0};
        t2    = (lq2 > r2_t1) ? lq2 - r2_t1 : '0;
        dfull = (r2_t1 > t2) ? r2_t1 - t2 : '0;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t6[i] = 20'(r3_ph[i]) * 20'd6;
            kk[i] = (r3_ph[i] < 17'd43690) ? 17'd43690 - r3_ph[i] : '0;
            if (t6[i] < 20'd65536) begin
                sec[i] = SEC_RISE;
                mul[i] = t6[i][15:0];
            end else if ({r3_ph[i], 1'b0} < 18'd65536) begin
                sec[i] = SEC_HIGH;
                mul[i] = '0;
            end else if (19'(r3_ph[i]) * 19'd3 < 19'd131072) begin
                sec[i] = SEC_FALL;
                mul[i] = 16'(kk[i] * 17'd6);
            end else begin
                sec[i] = SEC_LOW;
                mul[i] = '0;
            end
            prod[i] = 33'(r3_diff) * 33'(mul[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r4_sec[i])
                SEC_RISE: c[i] = 19'(r4_t2) + 19'(r4_add[i]);
                SEC_FALL: c[i] = 19'(r4_t2) + 19'(r4_add[i]);
                SEC_HIGH: c[i] = 19'(r4_t1);
                default:  c[i] = 19'(r4_t2);
            endcase
            cp[i] = 26'(c[i]) * 26'd100;
            p[i]  = (cp[i][25:16] > 10'd100) ? 7'd100 : cp[i][22:16];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pick[i] = r_meta[4].gray ? r_meta[4].v : r5_p[i];
            y51[i]  = 13'(pick[i]) * 13'd51;
            bp[i]   = 22'(r6_y[i]) * 22'd1639;   // floor(y/5)
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld   <= {r_vld[NST-2:0], i_valid};
            o_valid <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta[0] <= '{alpha: i_side.alpha, hue: i_hue, sat: i_sat,
                           light: i_side.light, v: i_side.v, gray: (i_sat == 7'd0)};
            for (int k = 1; k < NST; k++) r_meta[k] <= r_meta[k-1];
            r1_lq   <= q16_pct(i_side.v);
            r1_sq   <= q16_pct(i_sat);
            r1_hq   <= hq;
            r2_t1   <= t1;
            r2_lq   <= r1_lq;
            r3_t1   <= r2_t1;
            r3_t2   <= t2;
            r3_diff <= dfull[16:0];
            r4_t1   <= r3_t1;
            r4_t2   <= r3_t2;
            for (int i = 0; i < 3; i++) begin
                r2_ph[i]  <= ph[i];
                r3_ph[i]  <= r2_ph[i];
                r4_sec[i] <= sec[i];
                r4_add[i] <= prod[i][32:16];
                r5_p[i]   <= p[i];
                r6_y[i]   <= y51[i][12:2];
            end
            o_pix.out_red   <= bp[0][20:13];
            o_pix.out_green <= bp[1][20:13];
            o_pix.out_blue  <= bp[2][20:13];
            o_pix.out_alpha <= r_meta[NST-1].alpha;
            o_pix.hue_deg   <= r_meta[NST-1].hue;
            o_pix.sat_pct   <= r_meta[NST-1].sat;
            o_pix.light_pct <= r_meta[NST-1].light;
        end
    end

endmodule

>>> rtl/pixel_lightness_adjust.sv
// Top level of the pixel lightness adjust pipeline.
// Depth: 18 register stages (2 front, 9 divider, 7 back).
// Throughput: one pixel per clock while the skid holds no result.
// The 9-stage hue/saturation divider sets the depth.
// A one-entry skid register after the pipeline keeps o_ready off the i_ready path.
// Reset (synchronous, active low) clears all valid bits, the skid and both registers.
`timescale 1ns / 1ps
`include "pixel_lightness_adjust_macros.svh"
module pixel_lightness_adjust (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel request in
    input  logic                            i_valid,
    output logic                            o_ready,
    input  plad_pkg::t_pix_in               i_data,
    // result out
    output logic                            o_valid,
    input  logic                            i_ready,
    output plad_pkg::t_pix_out              o_data,
    // config writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    // config registers
    logic       r_darken;
    logic [6:0] r_step;

    // whole pipeline advances together unless the skid is holding a result
    logic en;

    logic                        fe_valid;
    plad_pkg::t_side             fe_side;
    logic [plad_pkg::DIV_NW-1:0] fe_num_s, fe_num_h;
    logic [plad_pkg::DIV_DW-1:0] fe_den_s, fe_den_h;

    logic            dv_valid;
    plad_pkg::t_side dv_side;
    logic [6:0]      dv_sat;
    logic [8:0]      dv_hue;

    logic               pl_valid;
    plad_pkg::t_pix_out pl_data;

    logic               r_sk_v;
    plad_pkg::t_pix_out r_sk_d;

    assign en          = !r_sk_v;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_darken <= 1'b0;
            r_step   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                plad_pkg::CFG_DARKEN: r_darken <= i_cfg_data[0];
                plad_pkg::CFG_STEP:   r_step   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    plad_rgb_to_hsl u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid && en),
        .i_pix   (i_data),
        .i_darken(r_darken),
        .i_step  (r_step),
        .o_valid (fe_valid),
        .o_side  (fe_side),
        .o_num_s (fe_num_s),
        .o_den_s (fe_den_s),
        .o_num_h (fe_num_h),
        .o_den_h (fe_den_h)
    );

    plad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fe_valid),
        .i_side  (fe_side),
        .i_num_s (fe_num_s),
        .i_den_s (fe_den_s),
        .i_num_h (fe_num_h),
        .i_den_h (fe_den_h),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_sat   (dv_sat),
        .o_hue   (dv_hue)
    );

    plad_hsl_to_rgb u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_hue   (dv_hue),
        .i_sat   (dv_sat),
        .o_valid (pl_valid),
        .o_pix   (pl_data)
    );

    // Skid: when the head result is not taken, park it and stall the pipe
    // from the next cycle on; drain the skid first to keep order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_ready) r_sk_v <= 1'b0;
        end else if (pl_valid && !i_ready) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) r_sk_d <= pl_data;
    end

    assign o_valid = r_sk_v || pl_valid;
    assign o_data  = r_sk_v ? r_sk_d : pl_data;

    `PLA_ASSERT_NEXT(a_skid_holds, r_sk_v && !i_ready, r_sk_v)
    `PLA_ASSERT_NEXT(a_step_write,
        i_cfg_valid && i_cfg_index == plad_pkg::CFG_STEP,
        r_step == $past(i_cfg_data[6:0]))
    `PLA_ASSERT_SAME(a_hsl_range, o_valid,
        o_data.hue_deg < 9'd360 && o_data.sat_pct <= 7'd100 && o_data.light_pct <= 7'd100)
    `PLA_ASSERT_SAME(a_gray_equal, o_valid && o_data.sat_pct == 7'd0,
        o_data.out_red == o_data.out_green && o_data.out_green == o_data.out_blue)

endmodule

>>> bench/pla_checker.sv
// Checker for pixel_lightness_adjust: watches the channels, predicts each result, compares.
`timescale 1ns / 1ps
module pla_checker
    import plad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  t_pix_in               i_data,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  t_pix_out              o_data,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint unsigned Q1   = 65536;
    localparam longint unsigned Q3RD = 21843;
    localparam longint unsigned Q2_3 = 43690;

    bit       darken_q;
    bit [6:0] step_q;
    t_pix_out expected_px[$];

    // channel percent at Q16 phase t
    function automatic int unsigned phase_pct(longint unsigned t1, longint unsigned t2,
                                              longint unsigned t);
        longint unsigned diff, c, k, p;
        diff = (t1 > t2) ? t1 - t2 : 0;
        if (t * 6 < Q1) begin
            c = t2 + ((diff * 6 * t) >> 16);
        end else if (t * 2 < Q1) begin
            c = t1;
        end else if (t * 3 < 2 * Q1) begin
            k = (t < Q2_3) ? Q2_3 - t : 0;
            c = t2 + ((diff * k * 6) >> 16);
        end else begin
            c = t2;
        end
        p = (c * 100) >> 16;
        if (p > 100) p = 100;
        return int'(p);
    endfunction

    function automatic logic [7:0] pct_byte(int unsigned p);
        int unsigned b;
        b = (p * 255) / 100;
        return (b > 255) ? 8'd255 : b[7:0];
    endfunction

    function automatic t_pix_out adjust_pixel(t_pix_in px, bit dk, bit [6:0] st);
        int r, g, b, mx, mn, sum, d, den, num;
        int unsigned hue, sat, light, v, pr, pg, pb;
        longint unsigned lq, sq, hq, t1, t2, tr, tb;
        t_pix_out res;
        r = px.red; g = px.green; b = px.blue;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d = mx - mn;
        light = (100 * sum) / 510;
        hue = 0; sat = 0;
        if (d > 0) begin
            den = (sum < 255) ? sum : 510 - sum;
            sat = (100 * d) / den;
            // blue wins ties, then green
            if (mx == b) num = 240 * d + 60 * (r - g);
            else if (mx == g) num = 120 * d + 60 * (b - r);
            else begin
                num = 60 * (g - b);
                if (num < 0) num += 360 * d;
            end
            hue = num / d;
        end
        if (dk) v = (st >= light) ? 0 : light - st;
        else begin
            v = light + st;
            if (v > 100) v = 100;
        end
        if (sat == 0) begin
            pr = v; pg = v; pb = v;
        end else begin
            lq = (longint'(v) * Q1) / 100;
            sq = (longint'(sat) * Q1) / 100;
            hq = (longint'(hue) * Q1) / 360;
            if (lq < Q1 / 2) t1 = (lq * (Q1 + sq)) >> 16;
            else t1 = lq + sq - ((lq * sq) >> 16);
            t2 = (2 * lq > t1) ? 2 * lq - t1 : 0;
            tr = hq + Q3RD;
            if (tr > Q1) tr -= Q1;
            tb = (hq >= Q3RD) ? hq - Q3RD : hq + Q1 - Q3RD;
            pr = phase_pct(t1, t2, tr);
            pg = phase_pct(t1, t2, hq);
            pb = phase_pct(t1, t2, tb);
        end
        res.out_red   = pct_byte(pr);
        res.out_green = pct_byte(pg);
        res.out_blue  = pct_byte(pb);
        res.out_alpha = px.alpha;
        res.hue_deg   = hue[8:0];
        res.sat_pct   = sat[6:0];
        res.light_pct = light[6:0];
        return res;
    endfunction

    assign o_pending = expected_px.size();

    always @(posedge i_clk) begin
        t_pix_out exp_px;
        if (!i_rst_n) begin
            darken_q = 1'b0;
            step_q = '0;
            expected_px.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DARKEN) darken_q = i_cfg_data[0];
                else if (i_cfg_index == CFG_STEP) step_q = i_cfg_data[6:0];
            end
            if (i_valid && o_ready) expected_px.push_back(adjust_pixel(i_data, darken_q, step_q));
            if (o_valid && i_ready) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected result %h", o_data);
                    o_fail_count++;
                end else begin
                    exp_px = expected_px.pop_front();
                    if (o_data.out_red !== exp_px.out_red) begin
                        $error("out_red exp %0d got %0d", exp_px.out_red, o_data.out_red);
                        o_fail_count++;
                    end
                    if (o_data.out_green !== exp_px.out_green) begin
                        $error("out_green exp %0d got %0d", exp_px.out_green, o_data.out_green);
                        o_fail_count++;
                    end
                    if (o_data.out_blue !== exp_px.out_blue) begin
                        $error("out_blue exp %0d got %0d", exp_px.out_blue, o_data.out_blue);
                        o_fail_count++;
                    end
                    if (o_data.out_alpha !== exp_px.out_alpha) begin
                        $error("out_alpha exp %0d got %0d", exp_px.out_alpha, o_data.out_alpha);
                        o_fail_count++;
                    end
                    if (o_data.hue_deg !== exp_px.hue_deg) begin
                        $error("hue_deg exp %0d got %0d", exp_px.hue_deg, o_data.hue_deg);
                        o_fail_count++;
                    end
                    if (o_data.sat_pct !== exp_px.sat_pct) begin
                        $error("sat_pct exp %0d got %0d", exp_px.sat_pct, o_data.sat_pct);
                        o_fail_count++;
                    end
                    if (o_data.light_pct !== exp_px.light_pct) begin
                        $error("light_pct exp %0d got %0d", exp_px.light_pct, o_data.light_pct);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb_top.sv
// Top of the pixel_lightness_adjust bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import plad_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int NUM_PHASES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_pix_in              i_data;
    logic                 o_valid;
    logic                 i_ready;
    t_pix_out             o_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    int  fail_count;
    int  pending;
    int  cycle_count;
    int  pixels_sent;
    bit  gaps_on;       // random idling on both sides when set
    bit  long_hold;     // asks the output side for one long stall

    pixel_lightness_adjust u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    pla_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: generous bound on the whole run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Output side: a stall of random length before each result while gaps are on,
    // plus one long stall on request so the pipeline and skid fill up.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = gaps_on ? $urandom_range(0, 13) : 0;
            if (long_hold) begin
                stall = 400;
                long_hold = 1'b0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Offer one pixel request; valid stays high across back-to-back requests.
    task automatic send_pixel(input t_pix_in px);
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    // Both registers in one burst, cfg valid held between the two writes.
    task automatic write_regs(input logic [7:0] mode_val, input logic [7:0] step_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DARKEN;
        i_cfg_data  <= mode_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_STEP;
        i_cfg_data  <= step_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender pauses until every result is back, then idles before the next phase.
    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    // Uniform pixels half the time; otherwise greys, ties and near-greys for the corners.
    function automatic t_pix_in rand_pixel();
        t_pix_in px;
        int kind;
        px = $urandom;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: px.green = px.red;
            2: px.blue  = px.green;
            3: px.blue  = px.red;
            4: begin
                px.green = px.red ^ 8'd1;
                px.blue  = px.red;
            end
            default: ;
        endcase
        return px;
    endfunction

    // Register settings per phase; raw bytes so upper bits get exercised too.
    logic [7:0] mode_by_phase [NUM_PHASES] = '{8'd0, 8'd0, 8'd1, 8'd1, 8'd2, 8'd3, 8'd0, 8'd1};
    logic [7:0] step_by_phase [NUM_PHASES] = '{8'd30, 8'd100, 8'd100, 8'd37, 8'd255, 8'd50,
                                               8'd128, 8'd0};

    t_pix_in directed [20] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0},     // black
        '{8'd255, 8'd255, 8'd255, 8'd255},   // white, brighten saturates
        '{8'd255, 8'd0,   8'd0,   8'd17},    // pure red
        '{8'd0,   8'd255, 8'd0,   8'd34},
        '{8'd0,   8'd0,   8'd255, 8'd51},
        '{8'd255, 8'd255, 8'd0,   8'd68},    // red/green tie
        '{8'd0,   8'd255, 8'd255, 8'd85},    // green/blue tie
        '{8'd255, 8'd0,   8'd255, 8'd102},   // red/blue tie
        '{8'd128, 8'd128, 8'd128, 8'd119},   // mid grey
        '{8'd128, 8'd127, 8'd127, 8'd136},   // barely coloured
        '{8'd127, 8'd128, 8'd0,   8'd153},   // max plus min sums to 128
        '{8'd1,   8'd0,   8'd0,   8'd170},
        '{8'd255, 8'd254, 8'd254, 8'd187},
        '{8'd200, 8'd50,  8'd100, 8'd204},   // red max, negative hue wrap
        '{8'd10,  8'd200, 8'd90,  8'd221},
        '{8'd60,  8'd20,  8'd240, 8'd238},
        '{8'd255, 8'd128, 8'd0,   8'd1},
        '{8'd3,   8'd2,   8'd1,   8'd2},
        '{8'd170, 8'd85,  8'd255, 8'd128},
        '{8'd254, 8'd1,   8'd127, 8'd254}
    };

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DARKEN;
        i_cfg_data  = '0;
        gaps_on     = 1'b0;
        long_hold   = 1'b0;
        pixels_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_regs(mode_by_phase[ph], step_by_phase[ph]);
            if (ph == 0) begin
                foreach (directed[k]) send_pixel(directed[k]);
            end
            // phase 1: one long receiver stall while input streams back to back
            if (ph == 1) long_hold = 1'b1;
            gaps_on = (ph % 3) != 1;
            for (int n = 0; n < 116; n++) send_pixel(rand_pixel());
            gaps_on = 1'b0;
            drain();
        end

        $display("covered %0d pixels across %0d register settings (brighten/darken, step 0..127)",
                 pixels_sent, NUM_PHASES);
        $display("with random gaps on both channels and one long output stall");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/plad_pkg.sv
rtl/plad_rgb_to_hsl.sv
rtl/plad_div.sv
rtl/plad_hsl_to_rgb.sv
rtl/pixel_lightness_adjust.sv
bench/pla_checker.sv
bench/tb_top.sv
